### rtl/rbmte_pkg.sv
package rbmte_pkg;

   // Field widths of the request and response transfers.
   localparam int KIND_W   = 3;
   localparam int PIDX_W   = 8;
   localparam int PARAM_W  = 16;
   localparam int VPOS_W   = 5;
   localparam int SITE_W   = 4;
   localparam int UIDX_W   = 6;
   localparam int ACT_W    = 24;

   localparam int DEF_SITES  = 16;
   localparam int DEF_BLOCKS = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD    = 3'd0,
      KIND_SET_VIS = 3'd1,
      KIND_RECOMP  = 3'd2,
      KIND_HOP     = 3'd3,
      KIND_READ    = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RC_BIAS,
      ST_RC_COL,
      ST_RC_LAST,
      ST_RC_WRITE,
      ST_HP_A,
      ST_HP_B,
      ST_HP_C,
      ST_HP_WRITE,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_DONE
   } state_type;

endpackage

### rtl/rbmte_if.sv
interface rbmte_req_if;
   logic                               valid;
   logic                               ready;
   logic [rbmte_pkg::KIND_W-1:0]       kind;
   logic [rbmte_pkg::PIDX_W-1:0]       param_index;
   logic signed [rbmte_pkg::PARAM_W-1:0] param_value;
   logic [rbmte_pkg::VPOS_W-1:0]       visible_position;
   logic                               visible_bit;
   logic                               spin_flag;
   logic [rbmte_pkg::SITE_W-1:0]       to_site;
   logic [rbmte_pkg::SITE_W-1:0]       from_site;
   logic [rbmte_pkg::UIDX_W-1:0]       unit_index;

   modport source (output valid, kind, param_index, param_value, visible_position,
                   visible_bit, spin_flag, to_site, from_site, unit_index,
                   input ready);
   modport sink (input valid, kind, param_index, param_value, visible_position,
                 visible_bit, spin_flag, to_site, from_site, unit_index,
                 output ready);
endinterface

interface rbmte_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rbmte_pkg::ACT_W-1:0] activation;
   logic                               saturated;

   modport source (output valid, activation, saturated, input ready);
   modport sink (input valid, activation, saturated, output ready);
endinterface

### rtl/rbmte_ram.sv
module rbmte_ram #(
   parameter int WIDTH = rbmte_pkg::PARAM_W,
   parameter int DEPTH = 2 * rbmte_pkg::DEF_SITES * rbmte_pkg::DEF_BLOCKS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rbm_theta_table_engine.sv
// Flow: load and set-visible finish in IDLE, read passes RD_ADDR and RD_DATA, hop
// and recompute loop over all hidden units; results leave through DONE and rsp_chan.
// Throughput: one item at a time; the shared accumulator adder and the single
// read port of the parameter memory take one weight per cycle in a recompute.
// Reset: synchronous; afterwards a clearing pass over all parameter addresses
// zeroes both memories while no request is taken.
module rbm_theta_table_engine #(
   parameter int SITES  = rbmte_pkg::DEF_SITES,
   parameter int BLOCKS = rbmte_pkg::DEF_BLOCKS
) (
   input  logic        clock,
   input  logic        reset,
   rbmte_req_if.sink   req_chan,
   rbmte_rsp_if.source rsp_chan
);

   localparam int NVIS      = 2 * SITES;
   localparam int NUNITS    = SITES * BLOCKS;
   localparam int BIAS_BASE = 2 * SITES * BLOCKS;
   localparam int NPARAMS   = BIAS_BASE + BLOCKS;
   localparam int SAW       = $clog2(SITES);
   localparam int BKW       = $clog2(BLOCKS);
   localparam int VAW       = $clog2(NVIS);
   localparam int UAW       = $clog2(NUNITS);
   localparam int PAW       = $clog2(NPARAMS);
   localparam int PW        = rbmte_pkg::PARAM_W;
   localparam int AW        = rbmte_pkg::ACT_W;
   localparam int RC_W      = PW + $clog2(NVIS + 1) + 1;
   localparam int ACC_W     = (RC_W > AW + 2) ? RC_W : AW + 2;
   localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'((1 << (AW - 1)) - 1);
   localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-(1 << (AW - 1)));

   rbmte_pkg::state_type state_ff, state_in;

   logic [PAW-1:0]  clr_ff, clr_in;
   logic [NVIS-1:0] vis_ff, vis_in;
   logic [UAW-1:0]  u_ff, u_in;
   logic [SAW-1:0]  i_ff, i_in;
   logic [BKW-1:0]  k_ff, k_in;
   logic [PAW-1:0]  base_ff, base_in;
   logic [SAW-1:0]  c_ff, c_in;
   logic            half_ff, half_in;
   logic [VAW-1:0]  colv_ff, colv_in;
   logic            take_ff, take_in;
   logic            first_ff, first_in;
   logic [SAW-1:0]  hto_ff, hto_in;
   logic [SAW-1:0]  hfrom_ff, hfrom_in;
   logic            hhalf_ff, hhalf_in;
   logic [UAW-1:0]  uidx_ff, uidx_in;
   logic            uok_ff, uok_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic            sat_ff, sat_in;
   logic [AW-1:0]   res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]   rsp_act_ff, rsp_act_in;
   logic            rsp_sat_ff, rsp_sat_in;

   logic            p_we;
   logic [PAW-1:0]  p_waddr, p_raddr;
   logic [PW-1:0]   p_wdata, p_rdata;
   logic            a_we;
   logic [UAW-1:0]  a_waddr, a_raddr;
   logic [AW-1:0]   a_wdata, a_rdata;

   logic [SAW-1:0]  wcol_c;
   logic            wcol_h;
   logic [SAW:0]    wsum;
   logic [SAW:0]    wmod;
   logic [PAW-1:0]  waddr;

   logic signed [ACC_W-1:0] add_a, add_b, add_y;
   logic                    add_sub;
   logic signed [ACC_W-1:0] p_ext, a_ext;
   logic [AW-1:0]           clip_val;
   logic                    clip_hit;

   logic [UAW-1:0]  u_nx;
   logic [SAW-1:0]  i_nx;
   logic [BKW-1:0]  k_nx;
   logic [PAW-1:0]  base_nx;
   logic            u_last;
   logic            req_fire;

   rbmte_ram #(.WIDTH(PW), .DEPTH(NPARAMS)) u_param_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   rbmte_ram #(.WIDTH(AW), .DEPTH(NUNITS)) u_act_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   // Kernel address by cyclic shift: block base, half offset, (unit + column) mod SITES.
   always_comb begin
      wsum = {1'b0, i_ff} + {1'b0, wcol_c};
      wmod = (wsum >= (SAW + 1)'(SITES)) ? wsum - (SAW + 1)'(SITES) : wsum;
      waddr = base_ff + (wcol_h ? PAW'(SITES) : '0) + PAW'(wmod);
   end

   assign p_ext = {{(ACC_W - PW){p_rdata[PW-1]}}, p_rdata};
   assign a_ext = {{(ACC_W - AW){a_rdata[AW-1]}}, a_rdata};
   assign add_y = add_sub ? add_a - add_b : add_a + add_b;

   always_comb begin
      clip_hit = 1'b0;
      clip_val = AW'(acc_ff);
      if (acc_ff > ACC_HI) begin
         clip_hit = 1'b1;
         clip_val = AW'(ACC_HI);
      end else if (acc_ff < ACC_LO) begin
         clip_hit = 1'b1;
         clip_val = AW'(ACC_LO);
      end
   end

   // Next hidden unit: unit index, offset within block, block and block base.
   always_comb begin
      u_last  = (u_ff == UAW'(NUNITS - 1));
      u_nx    = u_ff + 1'b1;
      i_nx    = i_ff + 1'b1;
      k_nx    = k_ff;
      base_nx = base_ff;
      if (i_ff == SAW'(SITES - 1)) begin
         i_nx    = '0;
         k_nx    = k_ff + 1'b1;
         base_nx = base_ff + PAW'(2 * SITES);
      end
   end

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == rbmte_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      vis_in       = vis_ff;
      u_in         = u_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      c_in         = c_ff;
      half_in      = half_ff;
      colv_in      = colv_ff;
      take_in      = take_ff;
      first_in     = first_ff;
      hto_in       = hto_ff;
      hfrom_in     = hfrom_ff;
      hhalf_in     = hhalf_ff;
      uidx_in      = uidx_ff;
      uok_in       = uok_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_act_in   = rsp_act_ff;
      rsp_sat_in   = rsp_sat_ff;
      p_we         = 1'b0;
      p_waddr      = '0;
      p_wdata      = '0;
      p_raddr      = '0;
      a_we         = 1'b0;
      a_waddr      = u_ff;
      a_wdata      = clip_val;
      a_raddr      = u_ff;
      wcol_c       = c_ff;
      wcol_h       = half_ff;
      add_a        = acc_ff;
      add_b        = '0;
      add_sub      = 1'b0;

      unique case (state_ff) inside
         rbmte_pkg::ST_CLEAR: begin
            p_we    = 1'b1;
            p_waddr = clr_ff;
            a_we    = (int'(clr_ff) < NUNITS);
            a_waddr = UAW'(clr_ff);
            a_wdata = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == PAW'(NPARAMS - 1)) begin
               state_in = rbmte_pkg::ST_IDLE;
            end
         end
         rbmte_pkg::ST_IDLE: begin
            if (req_fire) begin
               sat_in   = 1'b0;
               res_in   = '0;
               state_in = rbmte_pkg::ST_DONE;
               u_in     = '0;
               i_in     = '0;
               k_in     = '0;
               base_in  = '0;
               case (req_chan.kind)
                  rbmte_pkg::KIND_LOAD: begin
                     if (int'(req_chan.param_index) < NPARAMS) begin
                        p_we    = 1'b1;
                        p_waddr = PAW'(req_chan.param_index);
                        p_wdata = req_chan.param_value;
                     end
                  end
                  rbmte_pkg::KIND_SET_VIS: begin
                     if (int'(req_chan.visible_position) < NVIS) begin
                        vis_in[VAW'(req_chan.visible_position)] = req_chan.visible_bit;
                     end
                  end
                  rbmte_pkg::KIND_RECOMP: begin
                     state_in = rbmte_pkg::ST_RC_BIAS;
                  end
                  rbmte_pkg::KIND_HOP: begin
                     if (int'(req_chan.to_site) < SITES && int'(req_chan.from_site) < SITES) begin
                        hto_in   = SAW'(req_chan.to_site);
                        hfrom_in = SAW'(req_chan.from_site);
                        hhalf_in = !req_chan.spin_flag;
                        state_in = rbmte_pkg::ST_HP_A;
                     end
                  end
                  rbmte_pkg::KIND_READ: begin
                     uidx_in  = UAW'(req_chan.unit_index);
                     uok_in   = (int'(req_chan.unit_index) < NUNITS);
                     state_in = rbmte_pkg::ST_RD_ADDR;
                  end
                  default: begin
                     state_in = rbmte_pkg::ST_DONE;
                  end
               endcase
            end
         end
         rbmte_pkg::ST_RC_BIAS: begin
            p_raddr  = PAW'(BIAS_BASE) + PAW'(k_ff);
            take_in  = 1'b1;
            first_in = 1'b1;
            c_in     = '0;
            half_in  = 1'b0;
            colv_in  = '0;
            state_in = rbmte_pkg::ST_RC_COL;
         end
         rbmte_pkg::ST_RC_COL, rbmte_pkg::ST_RC_LAST: begin
            // Accumulate the word fetched in the cycle before; the bias starts the sum.
            add_a  = first_ff ? '0 : acc_ff;
            add_b  = take_ff ? p_ext : '0;
            acc_in = add_y;
            if (state_ff == rbmte_pkg::ST_RC_COL) begin
               p_raddr  = waddr;
               take_in  = vis_ff[colv_ff];
               first_in = 1'b0;
               colv_in  = colv_ff + 1'b1;
               if (c_ff == SAW'(SITES - 1)) begin
                  c_in    = '0;
                  half_in = 1'b1;
               end else begin
                  c_in = c_ff + 1'b1;
               end
               if (colv_ff == VAW'(NVIS - 1)) begin
                  state_in = rbmte_pkg::ST_RC_LAST;
               end
            end else begin
               state_in = rbmte_pkg::ST_RC_WRITE;
            end
         end
         rbmte_pkg::ST_RC_WRITE, rbmte_pkg::ST_HP_WRITE: begin
            a_we = 1'b1;
            if (clip_hit) begin
               sat_in = 1'b1;
            end
            u_in    = u_nx;
            i_in    = i_nx;
            k_in    = k_nx;
            base_in = base_nx;
            if (u_last) begin
               state_in = rbmte_pkg::ST_DONE;
            end else if (state_ff == rbmte_pkg::ST_RC_WRITE) begin
               state_in = rbmte_pkg::ST_RC_BIAS;
            end else begin
               state_in = rbmte_pkg::ST_HP_A;
            end
         end
         rbmte_pkg::ST_HP_A: begin
            wcol_c   = hto_ff;
            wcol_h   = hhalf_ff;
            p_raddr  = waddr;
            state_in = rbmte_pkg::ST_HP_B;
         end
         rbmte_pkg::ST_HP_B: begin
            wcol_c   = hfrom_ff;
            wcol_h   = hhalf_ff;
            p_raddr  = waddr;
            add_a    = a_ext;
            add_b    = p_ext;
            acc_in   = add_y;
            state_in = rbmte_pkg::ST_HP_C;
         end
         rbmte_pkg::ST_HP_C: begin
            add_b    = p_ext;
            add_sub  = 1'b1;
            acc_in   = add_y;
            state_in = rbmte_pkg::ST_HP_WRITE;
         end
         rbmte_pkg::ST_RD_ADDR: begin
            a_raddr  = uidx_ff;
            state_in = rbmte_pkg::ST_RD_DATA;
         end
         rbmte_pkg::ST_RD_DATA: begin
            res_in   = uok_ff ? a_rdata : '0;
            state_in = rbmte_pkg::ST_DONE;
         end
         rbmte_pkg::ST_DONE: begin
            // The result waits here until the output register is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_act_in   = res_ff;
               rsp_sat_in   = sat_ff;
               state_in     = rbmte_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rbmte_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbmte_pkg::ST_CLEAR;
         clr_ff       <= '0;
         vis_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         vis_ff       <= vis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff       <= u_in;
      i_ff       <= i_in;
      k_ff       <= k_in;
      base_ff    <= base_in;
      c_ff       <= c_in;
      half_ff    <= half_in;
      colv_ff    <= colv_in;
      take_ff    <= take_in;
      first_ff   <= first_in;
      hto_ff     <= hto_in;
      hfrom_ff   <= hfrom_in;
      hhalf_ff   <= hhalf_in;
      uidx_ff    <= uidx_in;
      uok_ff     <= uok_in;
      acc_ff     <= acc_in;
      sat_ff     <= sat_in;
      res_ff     <= res_in;
      rsp_act_ff <= rsp_act_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.activation = rsp_act_ff;
   assign rsp_chan.saturated  = rsp_sat_ff;

endmodule

### rtl/rbmte_checker.sv
module rbmte_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rbmte_pkg::ACT_W-1:0]  rsp_activation,
   input logic                         rsp_saturated
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] pending_ff, pending_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A response shows only for a request that has not yet been answered.
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without an outstanding request");

   // One request in work plus one result held at the output at most.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two requests outstanding");

   // Each request occupies the engine for at least the following cycle.
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("request taken back to back");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_activation)
                                  && $stable(rsp_saturated))
      else $error("stalled response changed");

endmodule

bind rbm_theta_table_engine rbmte_checker u_rbmte_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_activation (rsp_chan.activation),
   .rsp_saturated  (rsp_chan.saturated)
);

### verif/rbm_theta_table_engine_test.sv
module rbm_theta_table_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KIND_W  = rbmte_pkg::KIND_W;
   localparam int PIDX_W  = rbmte_pkg::PIDX_W;
   localparam int PARAM_W = rbmte_pkg::PARAM_W;
   localparam int VPOS_W  = rbmte_pkg::VPOS_W;
   localparam int SITE_W  = rbmte_pkg::SITE_W;
   localparam int UIDX_W  = rbmte_pkg::UIDX_W;
   localparam int ACT_W   = rbmte_pkg::ACT_W;

   localparam int SITES   = rbmte_pkg::DEF_SITES;
   localparam int BLOCKS  = rbmte_pkg::DEF_BLOCKS;
   localparam int NVIS    = 2 * SITES;
   localparam int NUNITS  = SITES * BLOCKS;
   localparam int NPARAMS = 2 * SITES * BLOCKS + BLOCKS;
   localparam int BIAS_BASE = 2 * SITES * BLOCKS;
   localparam longint ACT_MAX = (longint'(1) <<< (ACT_W - 1)) - 1;
   localparam longint ACT_MIN = -(longint'(1) <<< (ACT_W - 1));

   localparam int TARGET_ITEMS  = 1000;
   localparam int CALM_ITEMS    = 120;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRIFT_HOPS    = 140;
   localparam int RECOMP_CYCLES = (2 * SITES + 3) * SITES * BLOCKS + 3;

   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic [PIDX_W-1:0]        param_index;
      logic signed [PARAM_W-1:0] param_value;
      logic [VPOS_W-1:0]        visible_position;
      logic                     visible_bit;
      logic                     spin_flag;
      logic [SITE_W-1:0]        to_site;
      logic [SITE_W-1:0]        from_site;
      logic [UIDX_W-1:0]        unit_index;
   } request_type;

   typedef struct {
      logic signed [ACT_W-1:0] activation;
      logic                    saturated;
   } outcome_type;

   logic clock;
   logic reset;

   rbmte_req_if req_bus();
   rbmte_rsp_if rsp_bus();

   rbm_theta_table_engine dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow copy of the engine's stores.
   logic signed [PARAM_W-1:0] param_mem [NPARAMS] = '{default: '0};
   logic                      occupancy [NVIS] = '{default: 1'b0};
   logic signed [ACT_W-1:0]   activation_mem [NUNITS] = '{default: '0};

   request_type pending_requests[$];
   outcome_type expected_outcomes[$];

   logic req_taken;
   logic final_part;
   int   send_gap;
   int   rsp_gap;
   int   hold_left;
   logic hold_done;
   int   accepted_count = 0;
   int   checked_count = 0;
   int   mismatches = 0;
   int   saturated_count = 0;
   int   kind_seen [8] = '{default: 0};
   int   planned;

   function automatic longint weight_at(int unit, int col);
      int idx;
      idx = 2 * (unit / SITES) * SITES + (col / SITES) * SITES
            + ((unit % SITES) + (col % SITES)) % SITES;
      return longint'(param_mem[idx]);
   endfunction

   function automatic logic signed [ACT_W-1:0] clip_activation(longint v, inout logic clipped);
      if (v > ACT_MAX) begin
         clipped = 1'b1;
         return ACT_W'(ACT_MAX);
      end
      if (v < ACT_MIN) begin
         clipped = 1'b1;
         return ACT_W'(ACT_MIN);
      end
      return ACT_W'(v);
   endfunction

   function automatic outcome_type predict_outcome(request_type r);
      outcome_type o;
      longint      sum;
      int          base;
      o.activation = '0;
      o.saturated  = 1'b0;
      case (r.kind)
         rbmte_pkg::KIND_LOAD: begin
            if (r.param_index < NPARAMS)
               param_mem[r.param_index] = r.param_value;
         end
         rbmte_pkg::KIND_SET_VIS: begin
            if (r.visible_position < NVIS)
               occupancy[r.visible_position] = r.visible_bit;
         end
         rbmte_pkg::KIND_RECOMP: begin
            for (int u = 0; u < NUNITS; u++) begin
               sum = longint'(param_mem[BIAS_BASE + u / SITES]);
               for (int c = 0; c < NVIS; c++)
                  if (occupancy[c])
                     sum += weight_at(u, c);
               activation_mem[u] = clip_activation(sum, o.saturated);
            end
         end
         rbmte_pkg::KIND_HOP: begin
            if (r.to_site < SITES && r.from_site < SITES) begin
               // Spin down hops use the upper half of the columns.
               base = r.spin_flag ? 0 : SITES;
               for (int u = 0; u < NUNITS; u++) begin
                  sum = longint'(activation_mem[u]) + weight_at(u, base + r.to_site)
                        - weight_at(u, base + r.from_site);
                  activation_mem[u] = clip_activation(sum, o.saturated);
               end
            end
         end
         rbmte_pkg::KIND_READ: begin
            if (r.unit_index < NUNITS)
               o.activation = activation_mem[r.unit_index];
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic request_type random_request(logic [KIND_W-1:0] k);
      request_type r;
      r.kind             = k;
      r.param_index      = PIDX_W'($urandom_range(0, NPARAMS - 1));
      r.param_value      = PARAM_W'($urandom);
      r.visible_position = VPOS_W'($urandom_range(0, NVIS - 1));
      r.visible_bit      = 1'($urandom_range(0, 1));
      r.spin_flag        = 1'($urandom_range(0, 1));
      r.to_site          = SITE_W'($urandom_range(0, SITES - 1));
      r.from_site        = SITE_W'($urandom_range(0, SITES - 1));
      r.unit_index       = UIDX_W'($urandom_range(0, NUNITS - 1));
      return r;
   endfunction

   task automatic queue_request(request_type r);
      pending_requests.push_back(r);
      if (r.kind <= rbmte_pkg::KIND_READ
          && !(r.kind == rbmte_pkg::KIND_LOAD && r.param_index >= NPARAMS))
         planned++;
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_bus.valid || expected_outcomes.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic calm();
      return (final_part && pending_requests.size() < CALM_ITEMS)
             || ((accepted_count >> 6) % 3 == 2);
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("rbm_theta_table_engine_test failed");
      $finish;
   end

   // Request driver: holds an item until its transfer, then takes the next one.
   always @(negedge clock) begin
      request_type r;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else if (!req_bus.valid || req_taken) begin
         if (send_gap != 0) begin
            req_bus.valid <= 1'b0;
            send_gap      <= send_gap - 1;
         end else if (pending_requests.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (!calm() && $urandom_range(0, 9) == 0) begin
            req_bus.valid <= 1'b0;
            send_gap      <= $urandom_range(0, 7);
         end else begin
            r = pending_requests.pop_front();
            req_bus.valid            <= 1'b1;
            req_bus.kind             <= r.kind;
            req_bus.param_index      <= r.param_index;
            req_bus.param_value      <= r.param_value;
            req_bus.visible_position <= r.visible_position;
            req_bus.visible_bit      <= r.visible_bit;
            req_bus.spin_flag        <= r.spin_flag;
            req_bus.to_site          <= r.to_site;
            req_bus.from_site        <= r.from_site;
            req_bus.unit_index       <= r.unit_index;
         end
      end
   end

   // Long receiver hold-off, so that the engine backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && checked_count >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap       <= 0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap       <= rsp_gap - 1;
      end else if (!calm() && $urandom_range(0, 7) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap       <= $urandom_range(0, 7);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Monitor: checks each result transfer, then predicts for each request transfer.
   always @(posedge clock) begin
      request_type r;
      outcome_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            checked_count <= checked_count + 1;
            if (rsp_bus.saturated)
               saturated_count <= saturated_count + 1;
            if (expected_outcomes.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: activation %0d saturated %0b",
                           rsp_bus.activation, rsp_bus.saturated);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_bus.activation !== want.activation
                   || rsp_bus.saturated !== want.saturated) begin
                  if (mismatches < 10)
                     $display({"mismatch on result %0d: expected activation %0d",
                               " saturated %0b, got activation %0d saturated %0b"},
                              checked_count, want.activation, want.saturated,
                              rsp_bus.activation, rsp_bus.saturated);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            r.kind             = req_bus.kind;
            r.param_index      = req_bus.param_index;
            r.param_value      = req_bus.param_value;
            r.visible_position = req_bus.visible_position;
            r.visible_bit      = req_bus.visible_bit;
            r.spin_flag        = req_bus.spin_flag;
            r.to_site          = req_bus.to_site;
            r.from_site        = req_bus.from_site;
            r.unit_index       = req_bus.unit_index;
            expected_outcomes.push_back(predict_outcome(r));
            accepted_count <= accepted_count + 1;
            kind_seen[r.kind] <= kind_seen[r.kind] + 1;
         end
      end
   end

   initial begin
      request_type r;
      int          pick;
      int          blk;
      int          half;
      int          episodes;
      logic        sign;

      reset      = 1'b1;
      final_part = 1'b0;
      planned    = 0;
      episodes   = 0;

      // Directed part: field extremes, ignored loads, both hop halves, unknown kinds.
      r = random_request(rbmte_pkg::KIND_READ);   r.unit_index = '0;       queue_request(r);
      r = random_request(rbmte_pkg::KIND_LOAD);   r.param_index = '0;
      r.param_value = 16'sh7fff;                                          queue_request(r);
      r = random_request(rbmte_pkg::KIND_LOAD);
      r.param_index = PIDX_W'(NPARAMS - 1);
      r.param_value = -16'sh8000;                                         queue_request(r);
      r = random_request(rbmte_pkg::KIND_LOAD);   r.param_index = PIDX_W'(NPARAMS);
      r.param_value = 16'sh1234;                                          queue_request(r);
      r = random_request(rbmte_pkg::KIND_LOAD);   r.param_index = 8'hff;
      r.param_value = 16'sh5555;                                          queue_request(r);
      r = random_request(rbmte_pkg::KIND_LOAD);   r.param_index = PIDX_W'(BIAS_BASE);
      r.param_value = 16'sh0fff;                                          queue_request(r);
      r = random_request(rbmte_pkg::KIND_LOAD);   r.param_index = PIDX_W'(17);
      r.param_value = -16'sh0001;                                         queue_request(r);
      r = random_request(rbmte_pkg::KIND_SET_VIS); r.visible_position = '0;
      r.visible_bit = 1'b1;                                               queue_request(r);
      r = random_request(rbmte_pkg::KIND_SET_VIS);
      r.visible_position = VPOS_W'(NVIS - 1);
      r.visible_bit = 1'b1;                                               queue_request(r);
      r = random_request(rbmte_pkg::KIND_SET_VIS);
      r.visible_position = VPOS_W'(SITES);
      r.visible_bit = 1'b1;                                               queue_request(r);
      r = random_request(rbmte_pkg::KIND_SET_VIS);
      r.visible_position = VPOS_W'(1);
      r.visible_bit = 1'b0;                                               queue_request(r);
      r = random_request(rbmte_pkg::KIND_RECOMP);                         queue_request(r);
      r = random_request(rbmte_pkg::KIND_READ);   r.unit_index = '0;       queue_request(r);
      r = random_request(rbmte_pkg::KIND_READ);
      r.unit_index = UIDX_W'(NUNITS - 1);                                 queue_request(r);
      r = random_request(rbmte_pkg::KIND_HOP);    r.spin_flag = 1'b0;
      r.to_site = SITE_W'(SITES - 1);             r.from_site = '0;       queue_request(r);
      r = random_request(rbmte_pkg::KIND_HOP);    r.spin_flag = 1'b1;
      r.to_site = '0;                   r.from_site = SITE_W'(SITES - 1); queue_request(r);
      r = random_request(rbmte_pkg::KIND_READ);   r.unit_index = UIDX_W'(17); queue_request(r);
      r = random_request(rbmte_pkg::KIND_READ);   r.unit_index = UIDX_W'(48); queue_request(r);
      for (int j = 0; j < 3; j++) begin
         r = random_request(KIND_W'(rbmte_pkg::KIND_READ + 1 + j));
         queue_request(r);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // No new requests are queued here until the directed results are all in.
      wait_drained();
      final_part = 1'b1;

      while (planned < TARGET_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (episodes == 20 || episodes == 45) begin
            // Drive one weight half to alternating extremes and repeat a hop DRIFT_HOPS
            // times so that the activations clip in both directions.
            blk  = $urandom_range(0, BLOCKS - 1);
            r    = random_request(rbmte_pkg::KIND_HOP);
            half = r.spin_flag ? 0 : 1;
            sign = 1'($urandom_range(0, 1));
            for (int j = 0; j < SITES; j++) begin
               r = random_request(rbmte_pkg::KIND_LOAD);
               r.param_index = PIDX_W'(2 * blk * SITES + half * SITES + j);
               r.param_value = ((j % 2 == 0) ^ sign) ? 16'sh7fff : -16'sh8000;
               queue_request(r);
            end
            for (int j = 0; j < DRIFT_HOPS; j++) begin
               r = random_request(rbmte_pkg::KIND_HOP);
               r.spin_flag = (half == 0);
               r.to_site   = SITE_W'(1);
               r.from_site = '0;
               queue_request(r);
            end
            for (int j = 0; j < 6; j++) begin
               r = random_request(rbmte_pkg::KIND_READ);
               r.unit_index = UIDX_W'(blk * SITES + $urandom_range(0, SITES - 1));
               queue_request(r);
            end
            episodes++;
         end else if (pick < 8) begin
            // Well-formed episode: loads, occupations, a recompute, then hops and reads.
            for (int j = $urandom_range(0, 6); j > 0; j--) begin
               r = random_request(rbmte_pkg::KIND_LOAD);
               if ($urandom_range(0, 7) == 0)
                  r.param_index = PIDX_W'($urandom_range(NPARAMS, 255));
               if ($urandom_range(0, 3) == 0)
                  r.param_value = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
               queue_request(r);
            end
            for (int j = $urandom_range(0, 5); j > 0; j--)
               queue_request(random_request(rbmte_pkg::KIND_SET_VIS));
            queue_request(random_request(rbmte_pkg::KIND_RECOMP));
            for (int j = $urandom_range(2, 8); j > 0; j--)
               queue_request(random_request($urandom_range(0, 2) == 0
                                            ? rbmte_pkg::KIND_HOP : rbmte_pkg::KIND_READ));
            episodes++;
         end else begin
            for (int j = $urandom_range(1, 6); j > 0; j--) begin
               r = random_request(KIND_W'($urandom_range(0, 7)));
               // Keep noise away from the costly recompute most of the time.
               if (r.kind == rbmte_pkg::KIND_RECOMP && $urandom_range(0, 3) != 0)
                  r.kind = rbmte_pkg::KIND_READ;
               queue_request(r);
            end
         end
      end

      wait_drained();
      repeat (RECOMP_CYCLES) @(negedge clock);

      $display("covered %0d loads, %0d visible writes, %0d recomputes, %0d hops, %0d reads",
               kind_seen[rbmte_pkg::KIND_LOAD], kind_seen[rbmte_pkg::KIND_SET_VIS],
               kind_seen[rbmte_pkg::KIND_RECOMP], kind_seen[rbmte_pkg::KIND_HOP],
               kind_seen[rbmte_pkg::KIND_READ]);
      $display("%0d unknown kinds; %0d results checked, %0d flagged saturation, %0d mismatches",
               kind_seen[5] + kind_seen[6] + kind_seen[7],
               checked_count, saturated_count, mismatches);
      if (mismatches == 0 && expected_outcomes.size() == 0) begin
         $display("rbm_theta_table_engine_test passed");
      end else begin
         $display("rbm_theta_table_engine_test failed");
      end
      $finish;
   end

endmodule
